[rtl/mapc_pkg.sv]
// Package for the MMU access permission check block.
// Holds the shared codes, descriptor field constants and transaction structs.
// No dependencies.
package mapc_pkg;

  // Configuration register indexes (paddr bit 2)
  localparam logic CFG_DACR = 1'b0;
  localparam logic CFG_AFE  = 1'b1;

  localparam int unsigned PADDR_W = 3;

  // First-level descriptor types
  localparam logic [1:0] L1_FAULT   = 2'd0;
  localparam logic [1:0] L1_TABLE   = 2'd1;
  localparam logic [1:0] L1_SECTION = 2'd2;
  localparam logic [1:0] L1_RSVD    = 2'd3;

  localparam logic [1:0] L2_FAULT   = 2'd0;

  // DACR domain field encodings
  localparam logic [1:0] DOM_NOACC   = 2'd0;
  localparam logic [1:0] DOM_CLIENT  = 2'd1;
  localparam logic [1:0] DOM_RSVD    = 2'd2;
  localparam logic [1:0] DOM_MANAGER = 2'd3;

  // Access permission encodings {AP[2], AP[1:0]}
  localparam logic [2:0] AP_NONE     = 3'd0;
  localparam logic [2:0] AP_PRIV     = 3'd1;
  localparam logic [2:0] AP_USER_RO  = 3'd2;
  localparam logic [2:0] AP_FULL     = 3'd3;
  localparam logic [2:0] AP_RSVD     = 3'd4;
  localparam logic [2:0] AP_PRIV_RO  = 3'd5;
  localparam logic [2:0] AP_RO_ALT   = 3'd6;
  localparam logic [2:0] AP_RO       = 3'd7;

  // Fault kinds
  localparam logic [2:0] FK_NONE      = 3'd0;
  localparam logic [2:0] FK_TRANS_SEC = 3'd1;
  localparam logic [2:0] FK_TRANS_PG  = 3'd2;
  localparam logic [2:0] FK_PERM_SEC  = 3'd3;
  localparam logic [2:0] FK_PERM_PG   = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_RSVD_DESC  = 3'd1;
  localparam logic [2:0] ERR_RSVD_DOM   = 3'd2;
  localparam logic [2:0] ERR_RSVD_AP    = 3'd3;
  localparam logic [2:0] ERR_DOM_NOACC  = 3'd4;
  localparam logic [2:0] ERR_ACC_FLAG   = 3'd5;

  typedef struct packed {
    logic [31:0] dacr;
    logic        afe;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic        privileged;
    logic        is_write;
    logic [31:0] address;
    logic [31:0] first_descriptor;
    logic [31:0] second_descriptor;
  } req_t;

  typedef struct packed {
    logic        abort;
    logic [2:0]  fault_kind;
    logic [3:0]  fault_domain;
    logic [31:0] second_table_address;
    logic [2:0]  error;
  } rsp_t;

endpackage

[rtl/mapc_cfg_regs.sv]
// APB-style configuration registers: DACR and access-flag enable.
// Depends on mapc_pkg.
module mapc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mapc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output mapc_pkg::cfg_t                cfg_o
);

  logic [31:0] dacr_q;
  logic        afe_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dacr_q <= '0;
      afe_q  <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        mapc_pkg::CFG_DACR: dacr_q <= pwdata;
        mapc_pkg::CFG_AFE:  afe_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mapc_pkg::CFG_DACR: prdata = dacr_q;
      mapc_pkg::CFG_AFE:  prdata = {31'd0, afe_q};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.dacr = dacr_q;
  assign cfg_o.afe  = afe_q;

endmodule

[rtl/mapc_check.sv]
// Combinational permission decision for one registered access.
// Depends on mapc_pkg.
module mapc_check (
  input  mapc_pkg::req_t req_i,
  input  mapc_pkg::cfg_t cfg_i,
  output mapc_pkg::rsp_t rsp_o
);

  logic [1:0]  t1;
  logic [3:0]  dom;
  logic [1:0]  dbits;
  logic [2:0]  ap;
  logic        section;
  logic        deny;
  logic [31:0] sta;
  logic        priv;
  logic        wr;

  assign t1      = req_i.first_descriptor[1:0];
  assign dom     = req_i.first_descriptor[8:5];
  assign dbits   = cfg_i.dacr[{dom, 1'b0} +: 2];
  assign section = (t1 == mapc_pkg::L1_SECTION);
  assign priv    = req_i.privileged;
  assign wr      = req_i.is_write;
  assign ap      = section ? {req_i.first_descriptor[15], req_i.first_descriptor[11:10]}
                           : {req_i.second_descriptor[9], req_i.second_descriptor[5:4]};
  assign sta     = (t1 == mapc_pkg::L1_TABLE)
                 ? {req_i.first_descriptor[31:10], req_i.address[19:12], 2'b00} : '0;

  always_comb begin
    if (req_i.cmd) begin
      case (ap)
        mapc_pkg::AP_NONE:                       deny = 1'b1;
        mapc_pkg::AP_PRIV, mapc_pkg::AP_PRIV_RO: deny = ~priv;
        default:                                 deny = 1'b0;
      endcase
    end else begin
      case (ap)
        mapc_pkg::AP_NONE:    deny = 1'b1;
        mapc_pkg::AP_PRIV:    deny = ~priv;
        mapc_pkg::AP_USER_RO: deny = ~priv & wr;
        mapc_pkg::AP_FULL:    deny = 1'b0;
        mapc_pkg::AP_PRIV_RO: deny = ~priv | wr;
        default:              deny = wr;
      endcase
    end
  end

  always_comb begin
    rsp_o.abort                = 1'b0;
    rsp_o.fault_kind           = mapc_pkg::FK_NONE;
    rsp_o.fault_domain         = dom;
    rsp_o.second_table_address = sta;
    rsp_o.error                = mapc_pkg::ERR_NONE;
    // Priority follows the walk: translation, access flag, domain, then AP
    if (t1 == mapc_pkg::L1_FAULT) begin
      rsp_o.abort      = 1'b1;
      rsp_o.fault_kind = mapc_pkg::FK_TRANS_SEC;
    end else if (t1 == mapc_pkg::L1_RSVD) begin
      rsp_o.error = mapc_pkg::ERR_RSVD_DESC;
    end else if (t1 == mapc_pkg::L1_TABLE &&
                 req_i.second_descriptor[1:0] == mapc_pkg::L2_FAULT) begin
      rsp_o.abort      = 1'b1;
      rsp_o.fault_kind = mapc_pkg::FK_TRANS_PG;
    end else if (cfg_i.afe) begin
      rsp_o.error = mapc_pkg::ERR_ACC_FLAG;
    end else if (dbits == mapc_pkg::DOM_NOACC) begin
      rsp_o.error = mapc_pkg::ERR_DOM_NOACC;
    end else if (dbits == mapc_pkg::DOM_RSVD) begin
      rsp_o.error = mapc_pkg::ERR_RSVD_DOM;
    end else if (dbits == mapc_pkg::DOM_MANAGER) begin
      rsp_o.error = mapc_pkg::ERR_NONE;
    end else if (ap == mapc_pkg::AP_RSVD) begin
      rsp_o.error = mapc_pkg::ERR_RSVD_AP;
    end else if (deny) begin
      rsp_o.abort      = 1'b1;
      rsp_o.fault_kind = section ? mapc_pkg::FK_PERM_SEC : mapc_pkg::FK_PERM_PG;
    end
  end

endmodule

[rtl/mmu_access_permission_check_top.sv]
// Top level of the MMU access permission check block.
// Depends on mapc_pkg, mapc_cfg_regs and mapc_check.
//
// Usage:
//   Present one access on the request ports with start high; it is taken at
//   any rising edge where start is high and busy is low. busy is tied low, so
//   a new transaction can be issued every cycle.
//   The access is captured in an input register, checked by one level of
//   combinational logic and the outcome lands in a result register.
//   The result appears on the result ports once the result register has
//   captured it, marked by done_o for exactly one cycle, and is taken at
//   the edge that ends that cycle; the receiver cannot stall, so results are
//   never held back or dropped.
//   Throughput: one transaction per cycle.
//   Configuration (DACR at byte 0, access-flag enable at byte 4) uses the
//   APB-style port; write it only while no transaction is in flight.
//   Reset clears the configuration registers and the valid flags of both
//   stages; no result is produced for a transaction cut off by reset.
module mmu_access_permission_check_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mapc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic                          privileged_i,
  input  logic                          is_write_i,
  input  logic [31:0]                   address_i,
  input  logic [31:0]                   first_descriptor_i,
  input  logic [31:0]                   second_descriptor_i,
  output logic                          done_o,
  output logic                          abort_o,
  output logic [2:0]                    fault_kind_o,
  output logic [3:0]                    fault_domain_o,
  output logic [31:0]                   second_table_address_o,
  output logic [2:0]                    error_o
);

  mapc_pkg::cfg_t cfg;
  mapc_pkg::req_t req_d, req_q;
  mapc_pkg::rsp_t rsp_d, rsp_q;
  logic           req_vld_q;
  logic           rsp_vld_q;
  logic           accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  mapc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign req_d.cmd               = cmd_i;
  assign req_d.privileged        = privileged_i;
  assign req_d.is_write          = is_write_i;
  assign req_d.address           = address_i;
  assign req_d.first_descriptor  = first_descriptor_i;
  assign req_d.second_descriptor = second_descriptor_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      req_vld_q <= accept;
      rsp_vld_q <= req_vld_q;
    end
  end

  // Payload registers: capture only on a live transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
    end
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  mapc_check u_check (
    .req_i (req_q),
    .cfg_i (cfg),
    .rsp_o (rsp_d)
  );

  assign done_o                 = rsp_vld_q;
  assign abort_o                = rsp_q.abort;
  assign fault_kind_o           = rsp_q.fault_kind;
  assign fault_domain_o         = rsp_q.fault_domain;
  assign second_table_address_o = rsp_q.second_table_address;
  assign error_o                = rsp_q.error;

endmodule

[sim/tb_top.sv]
// Testbench for the MMU access permission check block: directed and random accesses
// under several DACR and access-flag settings, every outcome predicted and compared.
// Depends on mapc_pkg and mmu_access_permission_check_top.
`timescale 1ns / 100ps

module tb_top;
  import mapc_pkg::*;

  localparam logic CMD_DATA     = 1'b0;
  localparam logic CMD_FETCH    = 1'b1;
  localparam int   MAX_GAP      = 12;
  localparam int   SETTLE_LAT   = 4;
  localparam int   PHASES       = 10;
  localparam int   PHASE_ITEMS  = 125;

  class perm_scoreboard;
    cfg_t cfg;
    rsp_t outcomes_due[$];
    int   mismatches;

    function new();
      cfg        = '0;
      mismatches = 0;
    endfunction

    function rsp_t expected_outcome(req_t a);
      rsp_t       r;
      logic [1:0] l1_kind;
      logic [1:0] dom_ctl;
      logic [2:0] ap;
      logic       is_section;
      logic       deny;
      r          = '0;
      deny       = 1'b0;
      l1_kind    = a.first_descriptor[1:0];
      is_section = (l1_kind == L1_SECTION);
      r.fault_domain = a.first_descriptor[8:5];
      if (l1_kind == L1_TABLE)
        r.second_table_address = {a.first_descriptor[31:10], a.address[19:12], 2'b00};
      dom_ctl = cfg.dacr[{r.fault_domain, 1'b0} +: 2];
      ap = is_section ? {a.first_descriptor[15], a.first_descriptor[11:10]}
                      : {a.second_descriptor[9], a.second_descriptor[5:4]};
      if (l1_kind == L1_FAULT) begin
        r.abort      = 1'b1;
        r.fault_kind = FK_TRANS_SEC;
      end else if (l1_kind == L1_RSVD) begin
        r.error = ERR_RSVD_DESC;
      end else if (l1_kind == L1_TABLE && a.second_descriptor[1:0] == L2_FAULT) begin
        r.abort      = 1'b1;
        r.fault_kind = FK_TRANS_PG;
      end else if (cfg.afe) begin
        r.error = ERR_ACC_FLAG;
      end else if (dom_ctl == DOM_NOACC) begin
        r.error = ERR_DOM_NOACC;
      end else if (dom_ctl == DOM_RSVD) begin
        r.error = ERR_RSVD_DOM;
      end else if (dom_ctl == DOM_CLIENT) begin
        if (ap == AP_RSVD) begin
          r.error = ERR_RSVD_AP;
        end else begin
          if (a.cmd == CMD_FETCH) begin
            case (ap)
              AP_NONE:             deny = 1'b1;
              AP_PRIV, AP_PRIV_RO: deny = !a.privileged;
              default:             deny = 1'b0;
            endcase
          end else begin
            case (ap)
              AP_NONE:    deny = 1'b1;
              AP_PRIV:    deny = !a.privileged;
              AP_USER_RO: deny = !a.privileged && a.is_write;
              AP_FULL:    deny = 1'b0;
              AP_PRIV_RO: deny = !a.privileged || a.is_write;
              default:    deny = a.is_write;
            endcase
          end
          if (deny) begin
            r.abort      = 1'b1;
            r.fault_kind = is_section ? FK_PERM_SEC : FK_PERM_PG;
          end
        end
      end
      return r;
    endfunction

    function void note_access(req_t a);
      outcomes_due.push_back(expected_outcome(a));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (outcomes_due.size() == 0) begin
        $display("%0t: result with no access outstanding, expected none actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = outcomes_due.pop_front();
      compare_field("abort", 32'(want.abort), 32'(got.abort));
      compare_field("fault_kind", 32'(want.fault_kind), 32'(got.fault_kind));
      compare_field("fault_domain", 32'(want.fault_domain), 32'(got.fault_domain));
      compare_field("second_table_address", want.second_table_address,
                    got.second_table_address);
      compare_field("error", 32'(want.error), 32'(got.error));
    endfunction
  endclass

  logic                 clk_i               = 1'b0;
  logic                 rst_ni              = 1'b0;
  logic                 psel                = 1'b0;
  logic                 penable             = 1'b0;
  logic                 pwrite              = 1'b0;
  logic [PADDR_W-1:0]   paddr               = '0;
  logic [31:0]          pwdata              = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 start               = 1'b0;
  logic                 busy;
  logic                 cmd_i               = 1'b0;
  logic                 privileged_i        = 1'b0;
  logic                 is_write_i          = 1'b0;
  logic [31:0]          address_i           = '0;
  logic [31:0]          first_descriptor_i  = '0;
  logic [31:0]          second_descriptor_i = '0;
  logic                 done_o;
  logic                 abort_o;
  logic [2:0]           fault_kind_o;
  logic [3:0]           fault_domain_o;
  logic [31:0]          second_table_address_o;
  logic [2:0]           error_o;

  perm_scoreboard sb = new();
  bit             idle_on = 1'b1;

  mmu_access_permission_check_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Record each access at the edge that takes it
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      sb.note_access('{cmd: cmd_i, privileged: privileged_i, is_write: is_write_i,
                       address: address_i, first_descriptor: first_descriptor_i,
                       second_descriptor: second_descriptor_i});
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result('{abort: abort_o, fault_kind: fault_kind_o,
                        fault_domain: fault_domain_o,
                        second_table_address: second_table_address_o,
                        error: error_o});
  end

  function automatic int next_gap();
    return idle_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // Mostly sections and page tables; the rest faults and reserved types
  function automatic req_t random_access();
    req_t a;
    int   pick;
    a.cmd               = 1'($urandom_range(0, 1));
    a.privileged        = 1'($urandom_range(0, 1));
    a.is_write          = 1'($urandom_range(0, 1));
    a.address           = $urandom;
    a.first_descriptor  = $urandom;
    a.second_descriptor = $urandom;
    pick = $urandom_range(0, 19);
    if (pick < 2)       a.first_descriptor[1:0] = L1_FAULT;
    else if (pick < 3)  a.first_descriptor[1:0] = L1_RSVD;
    else if (pick < 11) a.first_descriptor[1:0] = L1_TABLE;
    else                a.first_descriptor[1:0] = L1_SECTION;
    if ($urandom_range(0, 7) == 0)
      a.second_descriptor[1:0] = L2_FAULT;
    else if (a.second_descriptor[1:0] == L2_FAULT)
      a.second_descriptor[1:0] = 2'($urandom_range(1, 3));
    return a;
  endfunction

  function automatic req_t shaped_access(logic [1:0] l1_kind, logic [3:0] dom,
                                         logic [2:0] ap, logic cmd, logic priv,
                                         logic wr);
    req_t a;
    a = random_access();
    a.cmd        = cmd;
    a.privileged = priv;
    a.is_write   = wr;
    a.first_descriptor[1:0]   = l1_kind;
    a.first_descriptor[8:5]   = dom;
    a.first_descriptor[11:10] = ap[1:0];
    a.first_descriptor[15]    = ap[2];
    a.second_descriptor[1]    = 1'b1;
    a.second_descriptor[5:4]  = ap[1:0];
    a.second_descriptor[9]    = ap[2];
    return a;
  endfunction

  // Favour client domains so the AP rules see most of the traffic
  function automatic logic [31:0] random_dacr();
    logic [31:0] v;
    for (int d = 0; d < 16; d++)
      v[2*d +: 2] = ($urandom_range(0, 3) < 2) ? DOM_CLIENT : 2'($urandom_range(0, 3));
    return v;
  endfunction

  // Called at a rising edge; returns at the edge that takes the transaction
  task automatic issue_access(req_t a, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start               <= 1'b1;
    cmd_i               <= a.cmd;
    privileged_i        <= a.privileged;
    is_write_i          <= a.is_write;
    address_i           <= a.address;
    first_descriptor_i  <= a.first_descriptor;
    second_descriptor_i <= a.second_descriptor;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start, wait for every outcome, then let the pipeline drain
  task automatic settle();
    start <= 1'b0;
    while (sb.outcomes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_LAT) @(posedge clk_i);
  endtask

  // Returns at the access edge with psel still high; the caller releases the bus
  task automatic apb_write(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == CFG_DACR) sb.cfg.dacr = value;
    else sb.cfg.afe = value[0];
  endtask

  task automatic configure(logic [31:0] dacr, logic afe);
    settle();
    apb_write(CFG_DACR, dacr);
    apb_write(CFG_AFE, {31'b0, afe});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    req_t a;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Domain 0 no access, 1 client, 2 reserved, 3 manager, the rest client
    configure(32'h5555_55E4, 1'b0);
    a = '0;
    a.first_descriptor = 32'hFFFF_FFFC;
    issue_access(a, next_gap());
    a = '1;
    a.first_descriptor[1:0] = L1_RSVD;
    issue_access(a, next_gap());
    a = '1;
    a.first_descriptor[1:0]  = L1_TABLE;
    a.second_descriptor[1:0] = L2_FAULT;
    issue_access(a, next_gap());
    a = '0;
    a.first_descriptor[1:0]  = L1_TABLE;
    a.second_descriptor[1:0] = 2'b01;
    issue_access(a, next_gap());
    for (int ap = 0; ap < 8; ap++)
      issue_access(shaped_access(L1_SECTION, 4'd1, 3'(ap), CMD_DATA, 1'b0, 1'b1),
                   next_gap());
    for (int ap = 0; ap < 8; ap++)
      issue_access(shaped_access(L1_TABLE, 4'd1, 3'(ap), CMD_FETCH, 1'b0,
                                 1'($urandom_range(0, 1))), next_gap());
    issue_access(shaped_access(L1_SECTION, 4'd2, AP_FULL, CMD_DATA, 1'b1, 1'b0),
                 next_gap());
    issue_access(shaped_access(L1_TABLE, 4'd3, AP_NONE, CMD_DATA, 1'b0, 1'b1),
                 next_gap());
    issue_access(shaped_access(L1_SECTION, 4'd1, AP_PRIV_RO, CMD_DATA, 1'b1, 1'b0),
                 next_gap());

    // Access flag enabled: translation faults still win
    configure(32'h5555_5555, 1'b1);
    issue_access(shaped_access(L1_SECTION, 4'd5, AP_FULL, CMD_DATA, 1'b1, 1'b1),
                 next_gap());
    issue_access(shaped_access(L1_FAULT, 4'd9, AP_FULL, CMD_FETCH, 1'b0, 1'b0),
                 next_gap());

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       configure(32'hFFFF_FFFF, 1'b0);
        1:       configure(32'h0000_0000, 1'b0);
        2:       configure(32'hAAAA_AAAA, 1'b0);
        3:       configure(random_dacr(), 1'b1);
        default: configure(random_dacr(), 1'b0);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Alternate bursts of back-to-back traffic with idle stretches
        if (i % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
        issue_access(random_access(), next_gap());
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.outcomes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
